// File: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: hdl/ssla_pkg.sv
package ssla_pkg;

    // table geometry
    localparam int SESSION_SLOTS = 32;
    localparam int SLOT_W        = $clog2(SESSION_SLOTS);

    // field widths of the item channels
    localparam int SLOT_FIELD_W  = 5;
    localparam int ID_W          = 32;
    localparam int SENDER_W      = 32;
    localparam int COUNT_W       = 32;
    localparam int ENTRY_W       = ID_W + SENDER_W;
    localparam int SLOT_CMP_W    = SLOT_W + SLOT_FIELD_W;

    // command codes
    localparam logic CMD_LOOKUP  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // result codes
    typedef enum logic [1:0] {
        OUTCOME_FOUND    = 2'd0,
        OUTCOME_CREATED  = 2'd1,
        OUTCOME_FULL     = 2'd2,
        OUTCOME_RELEASED = 2'd3
    } outcome_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } ssla_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_release;
        logic scan_done;
        logic out_free;
    } ssla_stat_t;

    // slot index as seen on the result field, masked to its width
    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_CMP_W-1:0] wide;
        wide = SLOT_CMP_W'(idx);
        return wide[SLOT_FIELD_W-1:0];
    endfunction

endpackage

// File: hdl/ssla_if.sv
// request channel
interface ssla_req_if
    import ssla_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [ID_W-1:0]         stream_id;
    logic [SENDER_W-1:0]     sender_address;
    logic [SLOT_FIELD_W-1:0] release_slot;

    modport source (output valid, command, stream_id, sender_address, release_slot,
                    input ready);
    modport sink (input valid, command, stream_id, sender_address, release_slot,
                  output ready);
endinterface

// response channel
interface ssla_rsp_if
    import ssla_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [1:0]              outcome;
    logic [COUNT_W-1:0]      creations_total;

    modport source (output valid, slot, outcome, creations_total, input ready);
    modport sink (input valid, slot, outcome, creations_total, output ready);
endinterface

// File: hdl/ssla_ram.sv
module ssla_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/ssla_ctrl.sv
module ssla_ctrl
    import ssla_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  ssla_stat_t stat,
    output ssla_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    // commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = req_valid && ready_reg;
                if (cmd.load)
                begin
                    ready_next = 1'b0;
                    state_next = (stat.is_release == CMD_RELEASE) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.commit = stat.out_free;
                if (stat.out_free)
                begin
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign req_ready = ready_reg;

endmodule

// File: hdl/ssla_dp.sv
module ssla_dp
    import ssla_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ssla_cmd_t               cmd,
    output ssla_stat_t              stat,
    input  logic                    command,
    input  logic [ID_W-1:0]         stream_id,
    input  logic [SENDER_W-1:0]     sender_address,
    input  logic [SLOT_FIELD_W-1:0] release_slot,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SLOT_FIELD_W-1:0] slot,
    output logic [1:0]              outcome,
    output logic [COUNT_W-1:0]      creations_total
);

    // captured request (payload)
    logic                    cmd_reg;
    logic [ID_W-1:0]         sid_reg;
    logic [SENDER_W-1:0]     sender_reg;
    logic [SLOT_FIELD_W-1:0] rel_reg;

    // scan pipeline
    logic [SLOT_W-1:0]       issue_idx_reg, issue_idx_next;
    logic                    issue_more_reg, issue_more_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                    found_reg, found_next;
    logic [SLOT_W-1:0]       found_idx_reg, found_idx_next;
    logic                    have_free_reg, have_free_next;
    logic [SLOT_W-1:0]       free_idx_reg, free_idx_next;

    // table state
    logic [SESSION_SLOTS-1:0] in_use_reg, in_use_next;
    logic [COUNT_W-1:0]       count_reg, count_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [SLOT_FIELD_W-1:0] out_slot_reg, out_slot_next;
    outcome_t                out_outcome_reg, out_outcome_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;

    // entry store
    logic                    ram_we;
    logic [ENTRY_W-1:0]      ram_rd_data;

    logic                    hit;
    logic                    last_cmp;
    logic                    rel_in_range;
    logic [SLOT_W-1:0]       rel_idx;

    ssla_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SESSION_SLOTS)
    ) u_entries (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (free_idx_reg),
        .wr_data ({sid_reg, sender_reg}),
        .rd_addr (issue_idx_reg),
        .rd_data (ram_rd_data)
    );

    // compare stage of the scan
    assign hit = cmp_valid_reg && in_use_reg[cmp_idx_reg]
                 && (ram_rd_data == {sid_reg, sender_reg});
    assign last_cmp = (cmp_idx_reg == SLOT_W'(SESSION_SLOTS - 1));

    // release target
    assign rel_in_range = (SLOT_CMP_W'(rel_reg) < SLOT_CMP_W'(SESSION_SLOTS));
    assign rel_idx      = SLOT_W'(rel_reg);

    function automatic logic cmd_valid_done();
        return cmp_valid_reg && (hit || last_cmp);
    endfunction

    // the controller looks at the command kind only while loading
    assign stat.is_release = command;
    assign stat.scan_done  = cmd_valid_done();
    assign stat.out_free   = !out_valid_reg || out_ready;

    // next-state logic
    always_comb
    begin
        issue_idx_next   = issue_idx_reg;
        issue_more_next  = issue_more_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        have_free_next   = have_free_reg;
        free_idx_next    = free_idx_reg;
        in_use_next      = in_use_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        out_slot_next    = out_slot_reg;
        out_outcome_next = out_outcome_reg;
        out_count_next   = out_count_reg;
        ram_we           = 1'b0;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            issue_idx_next  = '0;
            issue_more_next = 1'b1;
            found_next      = 1'b0;
            have_free_next  = 1'b0;
        end

        if (cmd.scan_step)
        begin
            // issue one read per cycle while slots remain to be read
            if (issue_more_reg)
            begin
                cmp_valid_next = 1'b1;
                cmp_idx_next   = issue_idx_reg;
                if (issue_idx_reg == SLOT_W'(SESSION_SLOTS - 1))
                begin
                    issue_more_next = 1'b0;
                end
                else
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
            end
            // check the entry read last cycle
            if (hit)
            begin
                found_next     = 1'b1;
                found_idx_next = cmp_idx_reg;
            end
            else if (cmp_valid_reg && !in_use_reg[cmp_idx_reg] && !have_free_reg)
            begin
                have_free_next = 1'b1;
                free_idx_next  = cmp_idx_reg;
            end
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            if (cmd_reg == CMD_RELEASE)
            begin
                if (rel_in_range)
                begin
                    in_use_next[rel_idx] = 1'b0;
                end
                out_slot_next    = rel_reg;
                out_outcome_next = OUTCOME_RELEASED;
            end
            else if (found_reg)
            begin
                out_slot_next    = slot_field(found_idx_reg);
                out_outcome_next = OUTCOME_FOUND;
            end
            else if (have_free_reg)
            begin
                in_use_next[free_idx_reg] = 1'b1;
                ram_we                    = 1'b1;
                count_next                = count_reg + 1'b1;
                out_slot_next             = slot_field(free_idx_reg);
                out_outcome_next          = OUTCOME_CREATED;
            end
            else
            begin
                out_slot_next    = '0;
                out_outcome_next = OUTCOME_FULL;
            end
            out_count_next = count_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_more_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            have_free_reg  <= 1'b0;
            in_use_reg     <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            issue_more_reg <= issue_more_next;
            cmp_valid_reg  <= cmp_valid_next;
            found_reg      <= found_next;
            have_free_reg  <= have_free_next;
            in_use_reg     <= in_use_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg    <= command;
            sid_reg    <= stream_id;
            sender_reg <= sender_address;
            rel_reg    <= release_slot;
        end
        issue_idx_reg   <= issue_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        found_idx_reg   <= found_idx_next;
        free_idx_reg    <= free_idx_next;
        out_slot_reg    <= out_slot_next;
        out_outcome_reg <= out_outcome_next;
        out_count_reg   <= out_count_next;
    end

    assign out_valid       = out_valid_reg;
    assign slot            = out_slot_reg;
    assign outcome         = out_outcome_reg;
    assign creations_total = out_count_reg;

endmodule

// File: hdl/stream_session_lookup_or_allocate_top.sv
// stream session table: lookup or allocate
//
// req channel: one item is a command (lookup or release), a stream id, a
// sender address and a release slot. rsp channel: one item per request with
// the slot, the outcome (found, created, full, released) and the running
// count of created sessions.
// a lookup reads the entry store one slot per cycle through its single
// registered read port, ascending, stopping at the first in-use match.
// one request is in flight at a time; the next can be taken in the cycle
// after the result is written.
// the result sits in an output register, so a new request is taken while
// the previous result waits; a stalled rsp holds its item and the block
// waits to write the next result until the register frees.
// reset clears all in-use marks and the creation count at once; the entry
// store is not cleared, and its data counts only for slots in use.
module stream_session_lookup_or_allocate_top
    import ssla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ssla_req_if.sink    req,
    ssla_rsp_if.source  rsp
);

`include "assert_macros.svh"

    ssla_cmd_t  cmd;
    ssla_stat_t stat;

    // sequencer
    ssla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table and result datapath
    ssla_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .command         (req.command),
        .stream_id       (req.stream_id),
        .sender_address  (req.sender_address),
        .release_slot    (req.release_slot),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .slot            (rsp.slot),
        .outcome         (rsp.outcome),
        .creations_total (rsp.creations_total)
    );

    // checks
    `ASSERT_ALWAYS(a_commit_needs_room, clk, rst_n, cmd.commit |-> stat.out_free)
    `ASSERT_ALWAYS(a_one_in_flight, clk, rst_n, (req.valid && req.ready) |=> !req.ready)
    `ASSERT_ALWAYS(a_ready_after_commit, clk, rst_n, cmd.commit |=> (req.ready && rsp.valid))
    `ASSERT_NEVER(a_load_commit_overlap, clk, rst_n, cmd.load && (cmd.commit || cmd.scan_step))

endmodule

// File: verif/tb_stream_session_lookup_or_allocate_top.sv
module tb_stream_session_lookup_or_allocate_top
    import ssla_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int KEY_POOL     = 48;
    localparam int LONG_STALL   = 300;
    localparam int SETTLE_WAIT  = 3 * SESSION_SLOTS;

    // one response item as the checker expects it
    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        outcome_t                outcome;
        logic [COUNT_W-1:0]      creations;
    } session_result_t;

    // shadow of the session table plus the queue of awaited responses
    class session_table_checker;
        bit                    in_use[SESSION_SLOTS];
        logic [ID_W-1:0]       stored_id[SESSION_SLOTS];
        logic [SENDER_W-1:0]   stored_sender[SESSION_SLOTS];
        logic [COUNT_W-1:0]    created;
        session_result_t       awaited[$];
        int                    errors;

        function new();
            foreach (in_use[i])
                in_use[i] = 1'b0;
            created = '0;
            errors  = 0;
        endfunction

        // apply one accepted request to the shadow table
        function void note_request(logic cmd, logic [ID_W-1:0] id,
                                   logic [SENDER_W-1:0] sender,
                                   logic [SLOT_FIELD_W-1:0] rel);
            session_result_t r;
            bit              have_free;
            bit              hit;
            int              free_idx;
            have_free = 1'b0;
            hit       = 1'b0;
            free_idx  = 0;
            r.slot    = '0;
            if (cmd == CMD_RELEASE)
            begin
                if (int'(rel) < SESSION_SLOTS)
                    in_use[rel] = 1'b0;
                r.slot    = rel;
                r.outcome = OUTCOME_RELEASED;
            end
            else
            begin
                // ascending scan, first in-use match wins
                for (int i = 0; i < SESSION_SLOTS && !hit; i++)
                begin
                    if (!in_use[i])
                    begin
                        if (!have_free)
                        begin
                            have_free = 1'b1;
                            free_idx  = i;
                        end
                    end
                    else if (stored_id[i] == id && stored_sender[i] == sender)
                    begin
                        hit    = 1'b1;
                        r.slot = SLOT_FIELD_W'(i);
                    end
                end
                if (hit)
                    r.outcome = OUTCOME_FOUND;
                else if (have_free)
                begin
                    in_use[free_idx]        = 1'b1;
                    stored_id[free_idx]     = id;
                    stored_sender[free_idx] = sender;
                    created                 = created + 1'b1;
                    r.slot                  = SLOT_FIELD_W'(free_idx);
                    r.outcome               = OUTCOME_CREATED;
                end
                else
                begin
                    r.slot    = '0;
                    r.outcome = OUTCOME_FULL;
                end
            end
            r.creations = created;
            awaited.push_back(r);
        endfunction

        // compare one accepted response with the oldest expectation
        function void check_response(logic [SLOT_FIELD_W-1:0] slot, logic [1:0] outcome,
                                     logic [COUNT_W-1:0] creations);
            session_result_t e;
            if (awaited.size() == 0)
            begin
                $display("%0t: response with nothing awaited: slot %0d outcome %0d count %0d",
                         $time, slot, outcome, creations);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (slot !== e.slot)
            begin
                $display("%0t: slot mismatch: expected %0d, actual %0d", $time, e.slot, slot);
                errors++;
            end
            if (outcome !== e.outcome)
            begin
                $display("%0t: outcome mismatch: expected %0d (%s), actual %0d",
                         $time, e.outcome, e.outcome.name(), outcome);
                errors++;
            end
            if (creations !== e.creations)
            begin
                $display("%0t: creation count mismatch: expected %0d, actual %0d",
                         $time, e.creations, creations);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   req_idle_pct;
    int   rsp_idle_pct;
    int   rsp_stall_left;

    logic [ID_W-1:0]     pool_id[KEY_POOL];
    logic [SENDER_W-1:0] pool_sender[KEY_POOL];

    session_table_checker table_check = new();

    ssla_req_if req_ch ();
    ssla_rsp_if rsp_ch ();

    stream_session_lookup_or_allocate_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                table_check.note_request(req_ch.command, req_ch.stream_id,
                                         req_ch.sender_address, req_ch.release_slot);
            if (rsp_ch.valid && rsp_ch.ready)
                table_check.check_response(rsp_ch.slot, rsp_ch.outcome,
                                           rsp_ch.creations_total);
        end
    end

    // response side backpressure, with an optional long hold-off
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rsp_stall_left > 0)
            begin
                rsp_stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // offer one item and hold it until accepted; called at a falling edge
    task automatic send_request(logic cmd, logic [ID_W-1:0] id,
                                logic [SENDER_W-1:0] sender,
                                logic [SLOT_FIELD_W-1:0] rel);
        if ($urandom_range(99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.stream_id      <= id;
        req_ch.sender_address <= sender;
        req_ch.release_slot   <= rel;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic lookup(logic [ID_W-1:0] id, logic [SENDER_W-1:0] sender);
        send_request(CMD_LOOKUP, id, sender, SLOT_FIELD_W'($urandom));
    endtask

    task automatic release_slot(logic [SLOT_FIELD_W-1:0] rel);
        send_request(CMD_RELEASE, $urandom, $urandom, rel);
    endtask

    // stop offering and wait until every response is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (table_check.pending() != 0)
            @(negedge clk);
    endtask

    // keys that partly share an id or a sender, so single-field matches occur
    task automatic build_key_pool();
        for (int i = 0; i < KEY_POOL; i++)
        begin
            pool_id[i]     = $urandom;
            pool_sender[i] = $urandom;
            if (i > 0 && $urandom_range(3) == 0)
                pool_id[i] = pool_id[i - 1];
            else if (i > 0 && $urandom_range(3) == 0)
                pool_sender[i] = pool_sender[i - 1];
        end
    endtask

    // random traffic: mostly pooled sessions, some fresh keys, some releases
    task automatic run_traffic(int items, int release_pct);
        int pick;
        int k;
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(99);
            k    = $urandom_range(KEY_POOL - 1);
            if (pick < release_pct)
                release_slot(SLOT_FIELD_W'($urandom));
            else if (pick < 85)
                lookup(pool_id[k], pool_sender[k]);
            else
                lookup($urandom, $urandom);
        end
    endtask

    initial
    begin
        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_LOOKUP;
        req_ch.stream_id      = '0;
        req_ch.sender_address = '0;
        req_ch.release_slot   = '0;
        req_idle_pct          = 0;
        rsp_idle_pct          = 0;
        rsp_stall_left        = 0;
        rst_n                 = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, partial matches, releases and reclaim
        lookup('0, '0);
        lookup('1, '1);
        lookup('0, '0);
        lookup('1, '0);
        lookup('0, '1);
        lookup('1, '1);
        release_slot(5'd0);
        release_slot(5'd0);
        lookup('0, '0);
        release_slot(5'd31);
        lookup(32'h1234_5678, 32'hA5A5_A5A5);
        release_slot(5'd2);
        lookup(32'hDEAD_BEEF, 32'h0A00_0001);
        lookup('1, '0);
        lookup(32'h1234_5678, 32'hA5A5_A5A5);
        release_slot(5'd4);
        lookup(32'h1234_5678, 32'hA5A5_A5A5);
        lookup(32'h8000_0000, 32'h0000_0001);
        lookup(32'h0000_0001, 32'h8000_0000);
        release_slot(5'd1);
        lookup(32'h5555_5555, 32'hAAAA_AAAA);
        drain();

        build_key_pool();

        // sender idles less, receiver idles more; starts with a long hold-off
        req_idle_pct   = 26;
        rsp_idle_pct   = 46;
        rsp_stall_left = LONG_STALL;
        run_traffic(300, 10);
        drain();

        // roles swapped
        req_idle_pct = 46;
        rsp_idle_pct = 26;
        run_traffic(300, 20);
        drain();

        // no idling
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        run_traffic(300, 14);
        drain();

        repeat (SETTLE_WAIT) @(posedge clk);
        if (table_check.pending() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, table_check.pending());
            table_check.errors++;
        end

        if (table_check.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
